// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define AST_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define AST_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: sv/ebalu_pkg.sv
// operation codes and helper types for the eight-bit alu
package ebalu_pkg;

  localparam int unsigned OpWidth   = 5;
  localparam int unsigned DataWidth = 8;

  typedef logic [OpWidth-1:0]   op_t;
  typedef logic [DataWidth-1:0] byte_t;

  // operation codes
  localparam op_t OP_ADD = 5'd0;
  localparam op_t OP_ADC = 5'd1;
  localparam op_t OP_SUB = 5'd2;
  localparam op_t OP_SBB = 5'd3;
  localparam op_t OP_ANA = 5'd4;
  localparam op_t OP_XRA = 5'd5;
  localparam op_t OP_ORA = 5'd6;
  localparam op_t OP_CMP = 5'd7;
  localparam op_t OP_INR = 5'd8;
  localparam op_t OP_DCR = 5'd9;
  localparam op_t OP_DAA = 5'd10;
  localparam op_t OP_RLC = 5'd11;
  localparam op_t OP_RRC = 5'd12;
  localparam op_t OP_RAL = 5'd13;
  localparam op_t OP_RAR = 5'd14;
  localparam op_t OP_CMA = 5'd15;
  localparam op_t OP_STC = 5'd16;
  localparam op_t OP_CMC = 5'd17;

  // decimal adjust constants
  localparam logic [3:0] BcdMax    = 4'h9;
  localparam byte_t      AdjLow    = 8'h06;
  localparam byte_t      AdjHigh   = 8'h60;

  // captured input item
  typedef struct packed {
    op_t   op;
    byte_t acc;
    byte_t opnd;
    logic  cy;
    logic  ac;
  } item_t;

endpackage

// File: sv/eight_bit_cpu_alu_with_flags.sv
// eight-bit accumulator alu with zero, sign, parity, carry and aux carry flags
//
// Usage:
//   An item is taken at a rising edge where start is high and busy is low.
//   busy is low whenever the block is out of reset, so one item can be
//   given in every cycle. Ports op, acc_in, operand, carry_in and
//   aux_carry_in carry the item.
//   Each item gives one result, shown on result, write_result and the five
//   flag outputs for exactly one cycle while done is high.
//   An item passes through the input register and then the result register;
//   its result is shown while done is high.
//   Throughput is one item per cycle outside reset, set by the input register,
//   a single adder pass and the result register.
//   The receiver cannot hold results off; it must take each one while done
//   is high.
//   Reset (rst, synchronous, active high) drops any item in flight and
//   holds busy high while asserted.
module eight_bit_cpu_alu_with_flags (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ebalu_pkg::op_t        op,
  input  ebalu_pkg::byte_t      acc_in,
  input  ebalu_pkg::byte_t      operand,
  input  logic                  carry_in,
  input  logic                  aux_carry_in,
  output logic                  done,
  output ebalu_pkg::byte_t      result,
  output logic                  write_result,
  output logic                  zero_flag,
  output logic                  sign_flag,
  output logic                  parity_flag,
  output logic                  carry_out,
  output logic                  aux_carry_out
);
  import ebalu_pkg::*;

  item_t      item;
  logic       item_vld;

  byte_t      add_b;
  logic       add_cin;
  logic [8:0] add_sum;
  logic [4:0] add_low;

  byte_t      res_next;
  logic       wr_next;
  logic       cy_next;
  logic       ac_next;
  byte_t      daa_corr;
  logic       daa_hi;

  // never stalls outside reset
  assign busy = rst;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else begin
      item_vld <= start && !busy;
    end
    if (start && !busy) begin
      item.op   <= op;
      item.acc  <= acc_in;
      item.opnd <= operand;
      item.cy   <= carry_in;
      item.ac   <= aux_carry_in;
    end
  end

  // decimal adjust correction
  always_comb begin
    daa_corr = '0;
    daa_hi   = item.cy || (item.acc[7:4] > BcdMax) ||
               ((item.acc[7:4] >= BcdMax) && (item.acc[3:0] > BcdMax));
    if ((item.acc[3:0] > BcdMax) || item.ac) begin
      daa_corr = daa_corr | AdjLow;
    end
    if (daa_hi) begin
      daa_corr = daa_corr | AdjHigh;
    end
  end

  // adder operand selection
  always_comb begin
    add_b   = item.opnd;
    add_cin = 1'b0;
    case (item.op)
      OP_ADC: begin
        add_cin = item.cy;
      end
      OP_SUB, OP_CMP: begin
        add_b   = ~item.opnd;
        add_cin = 1'b1;
      end
      OP_SBB: begin
        add_b   = ~item.opnd;
        add_cin = ~item.cy;
      end
      OP_INR: begin
        add_b = 8'h01;
      end
      OP_DCR: begin
        add_b = 8'hFF;
      end
      OP_DAA: begin
        add_b = daa_corr;
      end
      default: begin
        add_b = item.opnd;
      end
    endcase
  end

  // shared adder with carry out of bits three and seven
  assign add_sum = {1'b0, item.acc} + {1'b0, add_b} + {8'd0, add_cin};
  assign add_low = {1'b0, item.acc[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};

  // result and carry selection
  always_comb begin
    res_next = item.acc;
    wr_next  = 1'b1;
    cy_next  = item.cy;
    ac_next  = item.ac;
    case (item.op)
      OP_ADD, OP_ADC: begin
        res_next = add_sum[7:0];
        cy_next  = add_sum[8];
        ac_next  = add_low[4];
      end
      OP_SUB, OP_SBB: begin
        res_next = add_sum[7:0];
        cy_next  = ~add_sum[8];
        ac_next  = add_low[4];
      end
      OP_CMP: begin
        res_next = add_sum[7:0];
        cy_next  = ~add_sum[8];
        ac_next  = add_low[4];
        wr_next  = 1'b0;
      end
      OP_ANA: begin
        res_next = item.acc & item.opnd;
        cy_next  = 1'b0;
        ac_next  = 1'b0;
      end
      OP_XRA: begin
        res_next = item.acc ^ item.opnd;
        cy_next  = 1'b0;
        ac_next  = 1'b0;
      end
      OP_ORA: begin
        res_next = item.acc | item.opnd;
        cy_next  = 1'b0;
        ac_next  = 1'b0;
      end
      OP_INR, OP_DCR: begin
        res_next = add_sum[7:0];
        ac_next  = add_low[4];
      end
      OP_DAA: begin
        res_next = add_sum[7:0];
        ac_next  = add_low[4];
        cy_next  = item.cy | daa_hi;
      end
      OP_RLC: begin
        res_next = {item.acc[6:0], item.acc[7]};
        cy_next  = item.acc[7];
      end
      OP_RRC: begin
        res_next = {item.acc[0], item.acc[7:1]};
        cy_next  = item.acc[0];
      end
      OP_RAL: begin
        res_next = {item.acc[6:0], item.cy};
        cy_next  = item.acc[7];
      end
      OP_RAR: begin
        res_next = {item.cy, item.acc[7:1]};
        cy_next  = item.acc[0];
      end
      OP_CMA: begin
        res_next = ~item.acc;
      end
      OP_STC: begin
        cy_next = 1'b1;
        wr_next = 1'b0;
      end
      OP_CMC: begin
        cy_next = ~item.cy;
        wr_next = 1'b0;
      end
      default: begin
        // unused codes behave as no operation
        wr_next = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= item_vld;
    end
    if (item_vld) begin
      result        <= res_next;
      write_result  <= wr_next;
      zero_flag     <= (res_next == '0);
      sign_flag     <= res_next[7];
      parity_flag   <= ~(^res_next);
      carry_out     <= cy_next;
      aux_carry_out <= ac_next;
    end
  end

endmodule

// File: sv/ebalu_checker.sv
// port-level checks for the eight-bit alu, bound to the top level
`include "assert_macros.svh"

module ebalu_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input ebalu_pkg::byte_t      result,
  input logic                  zero_flag,
  input logic                  sign_flag,
  input logic                  parity_flag
);
  import ebalu_pkg::*;

  // every item taken is followed by a result with done high
  `AST_HOLDS(a_item_done, clk, rst, (start && !busy) |-> ##2 done, "item without result")

  // no result without an item taken earlier
  `AST_HOLDS(a_done_item, clk, rst, done |-> $past(start && !busy, 2), "result without item")

  // zero flag tracks the result byte
  `AST_HOLDS(a_zero, clk, rst, done |-> (zero_flag == (result == 8'h00)), "zero flag wrong")

  // sign and parity flags track the result byte
  `AST_HOLDS(a_sign_par, clk, rst,
    done |-> ((sign_flag == result[7]) && (parity_flag == ~(^result))), "sign or parity wrong")

  // the block never stalls outside reset
  `AST_NEVER(a_no_stall, clk, rst, busy, "busy outside reset")

endmodule

bind eight_bit_cpu_alu_with_flags ebalu_checker u_ebalu_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .result      (result),
  .zero_flag   (zero_flag),
  .sign_flag   (sign_flag),
  .parity_flag (parity_flag)
);
